FILE: hdl/btm_pkg.sv
// Shared types, sizes and mask tables for the binary thinning mask pass unit.
`timescale 1ns / 1ps
package btm_pkg;

	localparam int MAX_ROW_LENGTH = 1024;
	localparam int MAX_ROW_COUNT  = 4096;
	localparam int PTR_W          = $clog2(MAX_ROW_LENGTH);
	localparam int LEN_W          = 11;
	localparam int CNT_W          = 13;
	localparam int ROW_W          = $clog2(MAX_ROW_COUNT);
	localparam int UNC_N          = 50;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MODE       = 2'd0,
		REG_ROW_LENGTH = 2'd1,
		REG_ROW_COUNT  = 2'd2
	} reg_idx_t;

	// Pass modes
	typedef enum logic [1:0] {
		MODE_SHRINK   = 2'd0,
		MODE_THIN     = 2'd1,
		MODE_SKELETON = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	// Per-pixel position flags and line pointer from the raster counters
	typedef struct packed {
		logic             mark_ok;
		logic             out_vld;
		logic             out_ok;
		logic             last;
		logic [PTR_W-1:0] ptr;
	} pos_flags_t;

	// Unconditional patterns: {pattern, care, any-of group, set select}
	localparam logic [31:0] UNC_TAB [UNC_N] = '{
		32'h40FF0003, 32'h10FF0003, 32'h04FF0002, 32'h01FF0002,
		32'h02FF0003, 32'h80FF0003, 32'h20FF0002, 32'h08FF0002,
		32'hC0FF0001, 32'h60FF0001, 32'h30FF0001, 32'h18FF0001,
		32'h0CFF0001, 32'h06FF0001, 32'h03FF0001, 32'h81FF0001,
		32'hA0FF0002, 32'h28FF0002, 32'h0AFF0002, 32'h82FF0002,
		32'h68FF0001, 32'hB0FF0001, 32'hA1FF0001, 32'hC2FF0001,
		32'h445FA001, 32'h11D72801, 32'h44F50A01, 32'h117D8201,
		32'h38380003, 32'h83830002,
		32'hA8EB0001, 32'hA8BE0001, 32'h8ABE0001, 32'h8AEB0001,
		32'h2AAF0001, 32'h2AFA0001, 32'hA2FA0001, 32'hA2AF0001,
		32'hA8A80002, 32'h2A2A0002, 32'h8A8A0002, 32'hA2A20002,
		32'h50500703, 32'h1414C103, 32'h05057003, 32'h41411C03,
		32'hA4EE0003, 32'h29BB0003, 32'h4AEE0003, 32'h92BB0003
	};

	// Conditional bond set lookup: bit0 shrink, bit1 thin, bit2 skeleton
	function automatic logic cond_hit(input logic [7:0] b, input logic [1:0] mode);
		logic [2:0] modes;
		modes = 3'b000;
		case (b) inside
			8'h40, 8'h10, 8'h04, 8'h01, 8'h80, 8'h20, 8'h08, 8'h02,
			8'hC0, 8'h60, 8'h30, 8'h18, 8'h0C, 8'h06, 8'h03, 8'h81:
				modes = 3'b001;
			8'hA0, 8'h28, 8'h0A, 8'h82:
				modes = 3'b110;
			8'hB0, 8'hA1, 8'h68, 8'hC2, 8'hE0, 8'h38, 8'h0E, 8'h83,
			8'hB1, 8'h6C:
				modes = 3'b011;
			8'hC1, 8'h70, 8'h1C, 8'h07, 8'hF0, 8'hE1, 8'h78, 8'h3C,
			8'h1E, 8'h0F, 8'h87, 8'hC3, 8'hF1, 8'h7C, 8'h1F, 8'hC7,
			8'hE3, 8'hF8, 8'h3E, 8'h8F, 8'hF3, 8'hE7, 8'hFC, 8'hF9,
			8'h7E, 8'h3F, 8'h9F, 8'hCF, 8'hF7, 8'hFD, 8'h7F, 8'hDF:
				modes = 3'b111;
			8'hFB, 8'hFE, 8'hBF, 8'hEF:
				modes = 3'b100;
			default:
				modes = 3'b000;
		endcase
		return (mode != MODE_NONE) && modes[mode];
	endfunction

	// Unconditional pattern hit on the marked-neighbor byte
	function automatic logic unc_hit(input logic [7:0] b, input logic [1:0] mode);
		logic       hit;
		logic [7:0] sel;
		hit = 1'b0;
		sel = (mode == MODE_SKELETON) ? 8'h02 : 8'h01;
		for (int i = 0; i < UNC_N; i++) begin
			if (((UNC_TAB[i][7:0] & sel) != 8'h00) &&
			    ((b & UNC_TAB[i][23:16]) == UNC_TAB[i][31:24]) &&
			    ((UNC_TAB[i][15:8] == 8'h00) || ((b & UNC_TAB[i][15:8]) != 8'h00)))
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

FILE: hdl/btm_ram.sv
// Two-bit line store with one write port and one registered read port.
`timescale 1ns / 1ps
module btm_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [btm_pkg::PTR_W-1:0]  wr_addr,
	input  logic [1:0]                 wr_data,
	input  logic                       rd_en,
	input  logic [btm_pkg::PTR_W-1:0]  rd_addr,
	output logic [1:0]                 rd_data
);

	logic [1:0] mem [btm_pkg::MAX_ROW_LENGTH];

	// Write one entry per beat
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

FILE: hdl/btm_ctrl.sv
// Raster counters, line pointer and per-pixel position flags.
`timescale 1ns / 1ps
module btm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  logic                        frame_start,
	input  logic [btm_pkg::LEN_W-1:0]   len,
	input  logic [btm_pkg::CNT_W-1:0]   rows,
	output btm_pkg::pos_flags_t         flags
);

	logic [btm_pkg::LEN_W-1:0] col_q;
	logic [btm_pkg::ROW_W-1:0] row_q;
	logic [btm_pkg::PTR_W-1:0] col;
	logic [btm_pkg::CNT_W-1:0] row_inc;
	logic [btm_pkg::ROW_W-1:0] row;

	// Position of the current beat
	always_comb begin
		col     = col_q[btm_pkg::PTR_W-1:0];
		row_inc = {1'b0, row_q};
		if (frame_start) begin
			col     = '0;
			row_inc = '0;
		end else if (col_q >= len) begin
			col     = '0;
			row_inc = {1'b0, row_q} + 13'd1;
		end
		if (row_inc >= rows)
			row_inc = '0;
		row = row_inc[btm_pkg::ROW_W-1:0];
	end

	// Flags for the mark center and the output position; the column addresses the line stores
	always_comb begin
		flags.mark_ok = (row >= 12'd2) && (col >= 10'd2);
		flags.out_vld = (row >= 12'd3) || ((row == 12'd2) && (col >= 10'd2));
		flags.out_ok  = (row >= 12'd4) && (col >= 10'd4);
		flags.last    = ({1'b0, row} == rows - 13'd1) && ({1'b0, col} == len - 11'd1);
		flags.ptr     = col;
	end

	// Advance the raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= {1'b0, col} + 11'd1;
			row_q <= row;
		end
	end

endmodule

FILE: hdl/binary_thinning_mask_pass_unit.sv
// Top level of the binary thinning mask pass unit.
// Usage:
//   Pixels arrive in raster order on the input channel (in_valid, in_stall,
//   pixel_in, frame_start), one per beat; frame_start marks the first pixel.
//   Every accepted pixel yields one result beat on the output channel
//   (res_valid, res_stall, pixel_out, out_valid, out_last). pixel_out is the
//   thinned pixel two rows and two columns behind the input; out_valid is low
//   while that position is still before the frame, and out_last flags the
//   frame's final input pixel.
//   Throughput is one pixel per cycle while no result is held; an accepted
//   pixel passes the input register, mark stage and result register. Two line stores
//   (pixels and marks) each delay by one row through one registered read port.
//   Configuration (mode, row_length, row_count) is written through cfg_valid,
//   cfg_ready, cfg_index and cfg_data while no pixels are in flight.
//   Reset clears the pipeline, the counters and the registers to thin mode
//   and 1024 by 1024. The line stores need no clearing.
//   When res_stall is high with a result pending, the whole pipeline holds
//   and in_stall rises in the same cycle.
`timescale 1ns / 1ps
module binary_thinning_mask_pass_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        pixel_in,
	input  logic        frame_start,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        pixel_out,
	output logic        out_valid,
	output logic        out_last
);

	logic [1:0]                 mode_q;
	logic [10:0]                row_length_q;
	logic [12:0]                row_count_q;
	logic [10:0]                len;
	logic [12:0]                rows;
	logic                       adv, acc;
	btm_pkg::pos_flags_t        flags;

	logic                       v1_q, v2_q, v3_q;
	logic                       pix_s1;
	btm_pkg::pos_flags_t        flags_s1;
	logic [1:0]                 prd;
	logic                       p1_q, p2_q, a1_q, a2_q, b1_q, b2_q;
	logic [7:0]                 pbyte;
	logic                       mk1;

	logic                       mk_s2, pq_s2, outv_s2, outok_s2, last_s2;
	logic [btm_pkg::PTR_W-1:0]  ptr_s2;
	logic [1:0]                 mrd;
	logic                       m1_q, m2_q, ma1_q, ma2_q, mb1_q, mb2_q;
	logic [7:0]                 mbyte;
	logic                       erase;

	logic                       pix_s3, outv_s3, last_s3;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= btm_pkg::MODE_THIN;
			row_length_q <= 11'd1024;
			row_count_q  <= 13'd1024;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				btm_pkg::REG_MODE:       mode_q       <= cfg_data[1:0];
				btm_pkg::REG_ROW_LENGTH: row_length_q <= cfg_data[10:0];
				btm_pkg::REG_ROW_COUNT:  row_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp sizes to the supported range
	assign len  = (row_length_q < 11'd5) ? 11'd5 :
	              (row_length_q > 11'(btm_pkg::MAX_ROW_LENGTH)) ?
	              11'(btm_pkg::MAX_ROW_LENGTH) : row_length_q;
	assign rows = (row_count_q < 13'd5) ? 13'd5 :
	              (row_count_q > 13'(btm_pkg::MAX_ROW_COUNT)) ?
	              13'(btm_pkg::MAX_ROW_COUNT) : row_count_q;

	// Whole pipeline advances unless a result beat is held
	assign adv      = !(v3_q && res_stall);
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	btm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.frame_start (frame_start),
		.len         (len),
		.rows        (rows),
		.flags       (flags)
	);

	// Pixel line store: {row above, two rows above}
	btm_ram u_pix_ram (
		.clk     (clk),
		.wr_en   (v1_q && adv),
		.wr_addr (flags_s1.ptr),
		.wr_data ({pix_s1, prd[1]}),
		.rd_en   (acc),
		.rd_addr (flags.ptr),
		.rd_data (prd)
	);

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else if (adv) begin
			v1_q <= acc;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1   <= pixel_in;
			flags_s1 <= flags;
		end
	end

	// Shift the pixel window taps
	always_ff @(posedge clk) begin
		if (v1_q && adv) begin
			p1_q <= pix_s1;
			p2_q <= p1_q;
			a1_q <= prd[1];
			a2_q <= a1_q;
			b1_q <= prd[0];
			b2_q <= b1_q;
		end
	end

	// Mark test on the pixel one row and one column back
	assign pbyte = {prd[1], prd[0], b1_q, b2_q, a2_q, p2_q, p1_q, pix_s1};
	assign mk1   = a1_q && flags_s1.mark_ok && btm_pkg::cond_hit(pbyte, mode_q);

	// Mark stage
	always_ff @(posedge clk) begin
		if (v1_q && adv) begin
			mk_s2    <= mk1;
			pq_s2    <= b2_q;
			outv_s2  <= flags_s1.out_vld;
			outok_s2 <= flags_s1.out_ok;
			last_s2  <= flags_s1.last;
			ptr_s2   <= flags_s1.ptr;
		end
	end

	// Mark line store: {row above, two rows above}
	btm_ram u_mark_ram (
		.clk     (clk),
		.wr_en   (v2_q && adv),
		.wr_addr (ptr_s2),
		.wr_data ({mk_s2, mrd[1]}),
		.rd_en   (v1_q && adv),
		.rd_addr (flags_s1.ptr),
		.rd_data (mrd)
	);

	// Shift the mark window taps
	always_ff @(posedge clk) begin
		if (v2_q && adv) begin
			m1_q  <= mk_s2;
			m2_q  <= m1_q;
			ma1_q <= mrd[1];
			ma2_q <= ma1_q;
			mb1_q <= mrd[0];
			mb2_q <= mb1_q;
		end
	end

	// Erase a marked pixel with no unconditional hit
	assign mbyte = {mrd[1], mrd[0], mb1_q, mb2_q, ma2_q, m2_q, m1_q, mk_s2};
	assign erase = outok_s2 && ma1_q && !btm_pkg::unc_hit(mbyte, mode_q);

	// Result register
	always_ff @(posedge clk) begin
		if (v2_q && adv) begin
			pix_s3  <= outv_s2 && pq_s2 && !erase;
			outv_s3 <= outv_s2;
			last_s3 <= outv_s2 && last_s2;
		end
	end

	assign res_valid = v3_q;
	assign pixel_out = pix_s3;
	assign out_valid = outv_s3;
	assign out_last  = last_s3;

	// An invalid position carries no pixel and no frame end
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> !pixel_out && !out_last)
		else $error("invalid result beat carries data");

	// A mark is only raised on a foreground pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && mk1 |-> a1_q && flags_s1.mark_ok)
		else $error("mark on background or border pixel");

	// An accepted pixel enters the input register at the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v1_q)
		else $error("accepted pixel lost at input register");

	// A held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		v3_q && !adv |=> v3_q && $stable(pix_s3) && $stable(last_s3))
		else $error("result register changed while held");

endmodule

FILE: sim/tb_binary_thinning_mask_pass_unit.sv
// Self-checking testbench for the binary thinning mask pass unit.
`timescale 1ns / 1ps
module tb_binary_thinning_mask_pass_unit;
	import btm_pkg::*;

	localparam int RING_N     = 4 * MAX_ROW_LENGTH + 8;
	localparam int IDLE_LIMIT = 4000;
	localparam int ITEM_GOAL  = 1650;

	// Keep patterns of the marked-neighbor byte: {pattern, care, any-of, set}
	// Set bit 0 applies to shrink/thin, bit 1 to skeleton.
	localparam logic [31:0] KEEP_PAT [50] = '{
		32'h40FF0003, 32'h10FF0003, 32'h04FF0002, 32'h01FF0002,
		32'h02FF0003, 32'h80FF0003, 32'h20FF0002, 32'h08FF0002,
		32'hC0FF0001, 32'h60FF0001, 32'h30FF0001, 32'h18FF0001,
		32'h0CFF0001, 32'h06FF0001, 32'h03FF0001, 32'h81FF0001,
		32'hA0FF0002, 32'h28FF0002, 32'h0AFF0002, 32'h82FF0002,
		32'h68FF0001, 32'hB0FF0001, 32'hA1FF0001, 32'hC2FF0001,
		32'h445FA001, 32'h11D72801, 32'h44F50A01, 32'h117D8201,
		32'h38380003, 32'h83830002,
		32'hA8EB0001, 32'hA8BE0001, 32'h8ABE0001, 32'h8AEB0001,
		32'h2AAF0001, 32'h2AFA0001, 32'hA2FA0001, 32'hA2AF0001,
		32'hA8A80002, 32'h2A2A0002, 32'h8A8A0002, 32'hA2A20002,
		32'h50500703, 32'h1414C103, 32'h05057003, 32'h41411C03,
		32'hA4EE0003, 32'h29BB0003, 32'h4AEE0003, 32'h92BB0003
	};

	// Bond codes grouped by the modes that mark on them
	localparam logic [7:0] BOND_S [16] = '{
		8'h40, 8'h10, 8'h04, 8'h01, 8'h80, 8'h20, 8'h08, 8'h02,
		8'hC0, 8'h60, 8'h30, 8'h18, 8'h0C, 8'h06, 8'h03, 8'h81
	};
	localparam logic [7:0] BOND_TK [4] = '{8'hA0, 8'h28, 8'h0A, 8'h82};
	localparam logic [7:0] BOND_ST [10] = '{
		8'hB0, 8'hA1, 8'h68, 8'hC2, 8'hE0, 8'h38, 8'h0E, 8'h83, 8'hB1, 8'h6C
	};
	localparam logic [7:0] BOND_ALL [32] = '{
		8'hC1, 8'h70, 8'h1C, 8'h07, 8'hF0, 8'hE1, 8'h78, 8'h3C,
		8'h1E, 8'h0F, 8'h87, 8'hC3, 8'hF1, 8'h7C, 8'h1F, 8'hC7,
		8'hE3, 8'hF8, 8'h3E, 8'h8F, 8'hF3, 8'hE7, 8'hFC, 8'hF9,
		8'h7E, 8'h3F, 8'h9F, 8'hCF, 8'hF7, 8'hFD, 8'h7F, 8'hDF
	};
	localparam logic [7:0] BOND_K [4] = '{8'hFB, 8'hFE, 8'hBF, 8'hEF};

	typedef struct packed {
		logic pix;
		logic vld;
		logic last;
	} thin_result_t;

	typedef struct {
		bit pix;
		bit fs;
	} pixel_beat_t;

	// Predicts thinned pixels and checks result beats in order
	class thin_pass_scoreboard;
		bit           pix_ring [RING_N];
		bit           mark_ring [RING_N];
		logic [2:0]   bond_modes [256];
		int           col;
		int           row;
		mode_t        pass_mode;
		logic [10:0]  len_reg;
		logic [12:0]  cnt_reg;
		thin_result_t expected_px [$];
		int           errors;

		function new();
			foreach (pix_ring[i]) begin
				pix_ring[i]  = 1'b0;
				mark_ring[i] = 1'b0;
			end
			foreach (bond_modes[i]) bond_modes[i] = 3'b000;
			foreach (BOND_S[i]) bond_modes[BOND_S[i]] = 3'b001;
			foreach (BOND_TK[i]) bond_modes[BOND_TK[i]] = 3'b110;
			foreach (BOND_ST[i]) bond_modes[BOND_ST[i]] = 3'b011;
			foreach (BOND_ALL[i]) bond_modes[BOND_ALL[i]] = 3'b111;
			foreach (BOND_K[i]) bond_modes[BOND_K[i]] = 3'b100;
			col       = 0;
			row       = 0;
			pass_mode = MODE_THIN;
			len_reg   = 11'd1024;
			cnt_reg   = 13'd1024;
			errors    = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_reg(reg_idx_t idx, logic [12:0] val);
			case (idx)
				REG_MODE:       pass_mode = mode_t'(val[1:0]);
				REG_ROW_LENGTH: len_reg = val[10:0];
				REG_ROW_COUNT:  cnt_reg = val;
				default: ;
			endcase
		endfunction

		function bit rd(bit marks, int pos);
			return marks ? mark_ring[pos % RING_N] : pix_ring[pos % RING_N];
		endfunction

		// Gather the 8 neighbors, E in bit 7 then counterclockwise
		function logic [7:0] nbr(bit marks, int x, int w);
			return {rd(marks, x + 1), rd(marks, x - w + 1), rd(marks, x - w),
				rd(marks, x - w - 1), rd(marks, x - 1), rd(marks, x + w - 1),
				rd(marks, x + w), rd(marks, x + w + 1)};
		endfunction

		function bit bond_hit(logic [7:0] b);
			return (pass_mode != MODE_NONE) && bond_modes[b][pass_mode];
		endfunction

		function bit keep_hit(logic [7:0] b);
			logic [7:0] sel;
			bit         hit;
			sel = (pass_mode == MODE_SKELETON) ? 8'h02 : 8'h01;
			hit = 1'b0;
			foreach (KEEP_PAT[i]) begin
				if ((KEEP_PAT[i][7:0] & sel) != 8'h00 &&
				    (b & KEEP_PAT[i][23:16]) == KEEP_PAT[i][31:24] &&
				    (KEEP_PAT[i][15:8] == 8'h00 || (b & KEEP_PAT[i][15:8]) != 8'h00))
					hit = 1'b1;
			end
			return hit;
		endfunction

		// Advance the raster position and queue the result of one pixel
		function void note_pixel(bit pin, bit fs);
			int           w;
			int           h;
			int           p;
			int           m;
			int           q;
			bit           mk;
			thin_result_t r;
			w = (len_reg < 5) ? 5 : (len_reg > MAX_ROW_LENGTH ? MAX_ROW_LENGTH : int'(len_reg));
			h = (cnt_reg < 5) ? 5 : (cnt_reg > MAX_ROW_COUNT ? MAX_ROW_COUNT : int'(cnt_reg));
			if (fs) begin
				col = 0;
				row = 0;
			end else begin
				if (col >= w) begin
					col = 0;
					row++;
				end
				if (row >= h) row = 0;
			end
			p = row * w + col;
			pix_ring[p % RING_N] = pin;
			if (p >= w + 1) begin
				m  = p - w - 1;
				mk = 1'b0;
				if (rd(0, m) && m / w >= 1 && m / w <= h - 2 && m % w >= 1 &&
				    m % w <= w - 2 && bond_hit(nbr(0, m, w)))
					mk = 1'b1;
				mark_ring[m % RING_N] = mk;
			end
			r = '0;
			if (p >= 2 * w + 2) begin
				q     = p - 2 * w - 2;
				r.vld = 1'b1;
				r.pix = rd(0, q);
				if (r.pix && q / w >= 2 && q / w <= h - 3 && q % w >= 2 &&
				    q % w <= w - 3 && rd(1, q) && !keep_hit(nbr(1, q, w)))
					r.pix = 1'b0;
				r.last = (p == h * w - 1);
			end
			col++;
			expected_px = {expected_px, r};
		endfunction

		task check_result(logic pix, logic vld, logic last);
			thin_result_t e;
			if (expected_px.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				e = expected_px.pop_front();
				if (pix !== e.pix)
					report($sformatf("pixel_out %b, expected %b", pix, e.pix));
				if (vld !== e.vld)
					report($sformatf("out_valid %b, expected %b", vld, e.vld));
				if (last !== e.last)
					report($sformatf("out_last %b, expected %b", last, e.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        pixel_in;
	logic        frame_start;
	logic        res_valid;
	logic        res_stall;
	logic        pixel_out;
	logic        out_valid;
	logic        out_last;

	thin_pass_scoreboard sb = new();
	pixel_beat_t         pixel_beats [$];
	bit                  in_taken;
	bit                  cfg_taken;
	int                  idle_cycles;
	int                  items_sent;
	int                  stall_left;
	int                  stall_style;
	int                  stall_tick;

	binary_thinning_mask_pass_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_in    (pixel_in),
		.frame_start (frame_start),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.pixel_out   (pixel_out),
		.out_valid   (out_valid),
		.out_last    (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		in_taken  = 1'b0;
		cfg_taken = 1'b0;
		if (arst_n) begin
			in_taken  = in_valid && !in_stall;
			cfg_taken = cfg_valid && cfg_ready;
			if (in_taken) sb.note_pixel(pixel_in, frame_start);
			if (res_valid && !res_stall) sb.check_result(pixel_out, out_valid, out_last);
			if (in_taken || cfg_taken || (res_valid && !res_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("Some tests failed");
					$finish;
				end
			end
		end
	end

	// Receiver backpressure in random styles: none, random, mostly stalled or periodic
	always @(negedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_style = $urandom_range(0, 4);
				stall_left  = $urandom_range(20, 200);
			end
			stall_left--;
			stall_tick++;
			case (stall_style)
				0, 1:    res_stall <= 1'b0;
				2:       res_stall <= ($urandom_range(0, 3) == 0);
				3:       res_stall <= ($urandom_range(0, 9) < 7);
				default: res_stall <= (stall_tick % 5 == 0);
			endcase
		end
	end

	task write_reg(reg_idx_t idx, logic [12:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		while (!cfg_taken) @(negedge clk);
		cfg_valid = 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Drain the queued pixels in bursts with random gaps
	task send_pixels();
		int burst;
		pixel_beat_t b;
		burst = 0;
		while (pixel_beats.size() > 0) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0) begin
					in_valid = 1'b0;
					repeat ($urandom_range(1, 5)) @(negedge clk);
				end
			end
			b           = pixel_beats.pop_front();
			in_valid    = 1'b1;
			pixel_in    = b.pix;
			frame_start = b.fs;
			@(negedge clk);
			while (!in_taken) @(negedge clk);
			burst--;
			items_sent++;
		end
		in_valid = 1'b0;
	endtask

	// Hold until every expected result has come back
	task drain();
		while (sb.expected_px.size() > 0) @(negedge clk);
	endtask

	// Queue one frame with zero border, random interior, optional noise
	task queue_frame(int w, int h, int dens, bit noisy, bit fs, int cut);
		pixel_beat_t b;
		bit edge_px;
		for (int i = 0; i < w * h && i < cut; i++) begin
			edge_px = (i / w < 2) || (i / w >= h - 2) || (i % w < 2) || (i % w >= w - 2);
			if (edge_px)
				b.pix = noisy ? $urandom_range(0, 1) : 1'b0;
			else
				b.pix = ($urandom_range(0, 99) < dens);
			b.fs = (i == 0) ? fs : 1'b0;
			if (i != 0 && $urandom_range(0, 499) == 0) b.fs = 1'b1;
			pixel_beats = {pixel_beats, b};
		end
	endtask

	task config_all(mode_t md, logic [12:0] len, logic [12:0] cnt);
		write_reg(REG_MODE, {11'd0, md});
		write_reg(REG_ROW_LENGTH, len);
		write_reg(REG_ROW_COUNT, cnt);
	endtask

	initial begin
		int          frames;
		int          pick;
		mode_t       md;
		logic [12:0] len;
		logic [12:0] cnt;
		int          w;
		int          h;
		bit          fs;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_MODE;
		cfg_data    = '0;
		in_valid    = 1'b0;
		pixel_in    = 1'b0;
		frame_start = 1'b0;
		idle_cycles = 0;
		items_sent  = 0;
		stall_left  = 0;
		stall_style = 0;
		stall_tick  = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset sizes, no frame start on the first pixel
		queue_frame(1024, 1024, 60, 1'b1, 1'b0, 20);
		send_pixels();
		drain();

		// Smallest frame, all-ones interior and noisy border in skeleton mode
		config_all(MODE_SKELETON, 13'd5, 13'd5);
		queue_frame(5, 5, 100, 1'b1, 1'b1, 25);
		send_pixels();
		drain();

		// Random phases: mostly small frames, a few extreme or clamped sizes
		while (items_sent < ITEM_GOAL) begin
			md   = mode_t'($urandom_range(0, 3));
			pick = $urandom_range(0, 19);
			len  = $urandom_range(5, 14);
			cnt  = $urandom_range(5, 12);
			case (pick)
				0: len = $urandom_range(0, 4);
				1: len = 13'h1FFF;
				2: len = 13'd1024;
				3: cnt = 13'h1FFF;
				4: cnt = $urandom_range(0, 4);
				5: cnt = 13'd4096;
				default: ;
			endcase
			config_all(md, len, cnt);
			w = (len[10:0] < 5) ? 5 : (len[10:0] > 1024 ? 1024 : int'(len[10:0]));
			h = (cnt < 5) ? 5 : (cnt > 4096 ? 4096 : int'(cnt));
			if (w * h > 400) begin
				queue_frame(w, h, 70, $urandom_range(0, 1), 1'b1, $urandom_range(20, 80));
			end else begin
				frames = $urandom_range(2, 4);
				for (int f = 0; f < frames; f++) begin
					fs = (f == 0) || ($urandom_range(0, 3) != 0);
					queue_frame(w, h, $urandom_range(0, 3) == 0 ? 95 : $urandom_range(20, 85),
						$urandom_range(0, 4) == 0, fs,
						$urandom_range(0, 9) == 0 ? $urandom_range(1, w * h) : w * h);
				end
			end
			send_pixels();
			drain();
		end

		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.expected_px.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
